FILE: design/fixed_block_pool_allocator_assert.svh
// Assertion macros for the allocator's checker file
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

// Checked outside reset only
`define FBPA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fbpa assertion failed");

// Checked at every edge, reset included
`define FBPA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fbpa assertion failed");

`endif

FILE: design/fbpa_pkg.sv
// Package: constants, types and codes of the fixed block pool allocator
`default_nettype none

package fbpa_pkg;

  localparam int MAX_BLOCKS = 1024;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int HEAD_W     = $clog2(MAX_BLOCKS + 1);
  localparam logic [HEAD_W-1:0] HEAD_MAX = HEAD_W'(MAX_BLOCKS);

  localparam int ADDR_W  = 48;
  localparam int SIZE_W  = 32;
  localparam int BLOCK_W = 16;
  localparam int PROD_W  = HEAD_W + BLOCK_W;
  localparam int CNT_W   = $clog2(SIZE_W);

  localparam logic [BLOCK_W-1:0] MIN_BLOCK = BLOCK_W'(8);
  localparam logic [SIZE_W-1:0]  MAX_QUO   = SIZE_W'(MAX_BLOCKS);

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_SIZE  = 2'd1;
  localparam logic [1:0] REG_BLOCK = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2,
    ST_BAD_CFG = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CFG_CHK,
    S_CFG_DIV,
    S_DISPATCH,
    S_ALLOC_POP,
    S_MUL,
    S_ADD,
    S_FREE_DIV,
    S_RESP
  } fbpa_state_t;

  typedef struct packed {
    logic    load_req;
    logic    div_start;
    logic    div_sel_free;
    logic    store_n;
    logic    link_rd;
    logic    pop;
    logic    take_new;
    logic    mul_en;
    logic    add_en;
    logic    push;
    logic    set_status;
    status_t status_code;
  } fbpa_cmd_t;

  typedef struct packed {
    logic func_free;
    logic cfg_quick_bad;
    logic div_done;
    logic div_bad_cfg;
    logic div_bad_free;
    logic head_valid;
    logic have_untouched;
    logic addr_out_of_range;
  } fbpa_stat_t;

endpackage

`default_nettype wire

FILE: design/fbpa_div.sv
// Restoring divider, one quotient bit per cycle
`default_nettype none

module fbpa_div import fbpa_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [SIZE_W-1:0]  dividend,
  input  wire logic [BLOCK_W-1:0] divisor,
  output logic                    done,
  output logic [SIZE_W-1:0]       quotient,
  output logic [BLOCK_W-1:0]      remainder
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SIZE_W-1:0]  quo_r, quo_nxt;
  logic [BLOCK_W-1:0] rem_r, rem_nxt;
  logic [BLOCK_W-1:0] dvs_r, dvs_nxt;
  logic [BLOCK_W:0]   trial;
  logic [BLOCK_W:0]   diff;
  logic               fits;

  assign trial = {rem_r, quo_r[SIZE_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[SIZE_W-2:0], fits};
      rem_nxt = fits ? diff[BLOCK_W-1:0] : trial[BLOCK_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(SIZE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

FILE: design/fbpa_datapath.sv
// Datapath: configuration, free list, link memory, divider and address arithmetic
`default_nettype none

module fbpa_datapath import fbpa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [ADDR_W-1:0] cfg_wdata,
  input  wire logic              in_func,
  input  wire logic [ADDR_W-1:0] in_block_address,
  input  wire fbpa_cmd_t         cmd,
  output fbpa_stat_t             stat,
  output logic [1:0]             out_status,
  output logic [ADDR_W-1:0]      out_granted_address
);

  logic [ADDR_W-1:0]  base_r;
  logic [SIZE_W-1:0]  size_r;
  logic [BLOCK_W-1:0] bs_r;
  logic [HEAD_W-1:0]  head_r;
  logic [HEAD_W-1:0]  untouched_r;
  logic [HEAD_W-1:0]  n_r;
  logic [HEAD_W-1:0]  idx_r;
  logic [HEAD_W-1:0]  link_rd_r;
  logic [PROD_W-1:0]  prod_r;
  logic               func_r;
  logic [ADDR_W-1:0]  addr_r;
  status_t            status_r;
  logic [ADDR_W-1:0]  granted_r;

  logic [HEAD_W-1:0]  link_mem [MAX_BLOCKS];

  logic [ADDR_W:0]    pool_end;
  logic [ADDR_W-1:0]  offset;
  logic [SIZE_W-1:0]  div_dividend;
  logic               div_done;
  logic [SIZE_W-1:0]  div_quo;
  logic [BLOCK_W-1:0] div_rem;
  logic [HEAD_W-1:0]  link_clamped;

  assign pool_end     = {1'b0, base_r} + (ADDR_W + 1)'(size_r);
  assign offset       = addr_r - base_r;
  assign div_dividend = cmd.div_sel_free ? offset[SIZE_W-1:0] : size_r;
  assign link_clamped = (link_rd_r > HEAD_MAX) ? HEAD_MAX : link_rd_r;

  fbpa_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (bs_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    stat.func_free         = func_r == FUNC_FREE;
    stat.cfg_quick_bad     = (base_r == '0) || (size_r == '0) || (bs_r < MIN_BLOCK);
    stat.div_done          = div_done;
    stat.div_bad_cfg       = (div_rem != '0) || (div_quo > MAX_QUO);
    stat.div_bad_free      = (div_rem != '0) || (div_quo >= MAX_QUO);
    stat.head_valid        = head_r < HEAD_MAX;
    stat.have_untouched    = untouched_r < n_r;
    stat.addr_out_of_range = (addr_r < base_r) || ({1'b0, addr_r} >= pool_end);
  end

  // Configuration and free list control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      size_r      <= '0;
      bs_r        <= MIN_BLOCK;
      head_r      <= HEAD_MAX;
      untouched_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE: begin
          base_r      <= cfg_wdata;
          head_r      <= HEAD_MAX;
          untouched_r <= '0;
        end
        REG_SIZE: begin
          size_r      <= cfg_wdata[SIZE_W-1:0];
          head_r      <= HEAD_MAX;
          untouched_r <= '0;
        end
        REG_BLOCK: begin
          bs_r        <= cfg_wdata[BLOCK_W-1:0];
          head_r      <= HEAD_MAX;
          untouched_r <= '0;
        end
        default: begin
        end
      endcase
    end else begin
      if (cmd.pop) begin
        head_r <= link_clamped;
      end else if (cmd.push) begin
        head_r <= div_quo[HEAD_W-1:0];
      end
      if (cmd.take_new) begin
        untouched_r <= untouched_r + HEAD_W'(1);
      end
    end
  end

  // Link memory
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      link_mem[div_quo[IDX_W-1:0]] <= head_r;
    end
    if (cmd.link_rd) begin
      link_rd_r <= link_mem[head_r[IDX_W-1:0]];
    end
  end

  // Request payload and arithmetic
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      func_r    <= in_func;
      addr_r    <= in_block_address;
      status_r  <= ST_OK;
      granted_r <= '0;
    end else begin
      if (cmd.set_status) begin
        status_r <= cmd.status_code;
      end
      if (cmd.add_en) begin
        granted_r <= base_r + ADDR_W'(prod_r);
      end
    end
    if (cmd.store_n) begin
      n_r <= div_quo[HEAD_W-1:0];
    end
    if (cmd.pop) begin
      idx_r <= head_r;
    end else if (cmd.take_new) begin
      idx_r <= untouched_r;
    end
    if (cmd.mul_en) begin
      prod_r <= idx_r * bs_r;
    end
  end

  assign out_status          = status_r;
  assign out_granted_address = granted_r;

endmodule

`default_nettype wire

FILE: design/fbpa_ctrl.sv
// Controller: sequences one request through check, divide, list update and result
`default_nettype none

module fbpa_ctrl import fbpa_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire fbpa_stat_t stat,
  output fbpa_cmd_t       cmd,
  output logic            busy,
  output logic            out_valid
);

  fbpa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_CFG_CHK;
      end
      S_CFG_CHK: begin
        state_nxt = stat.cfg_quick_bad ? S_RESP : S_CFG_DIV;
      end
      S_CFG_DIV: begin
        if (stat.div_done) state_nxt = stat.div_bad_cfg ? S_RESP : S_DISPATCH;
      end
      S_DISPATCH: begin
        priority if (stat.func_free) begin
          state_nxt = stat.addr_out_of_range ? S_RESP : S_FREE_DIV;
        end else if (stat.head_valid) begin
          state_nxt = S_ALLOC_POP;
        end else if (stat.have_untouched) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_ALLOC_POP: state_nxt = S_MUL;
      S_MUL:       state_nxt = S_ADD;
      S_ADD:       state_nxt = S_RESP;
      S_FREE_DIV: begin
        if (stat.div_done) state_nxt = S_RESP;
      end
      S_RESP:      state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd       = '0;
    cmd.status_code = ST_OK;
    busy      = state_r != S_IDLE;
    out_valid = state_r == S_RESP;
    unique case (state_r)
      S_IDLE: begin
        cmd.load_req = start;
      end
      S_CFG_CHK: begin
        if (stat.cfg_quick_bad) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_BAD_CFG;
        end else begin
          cmd.div_start = 1'b1;
        end
      end
      S_CFG_DIV: begin
        if (stat.div_done) begin
          if (stat.div_bad_cfg) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_BAD_CFG;
          end else begin
            cmd.store_n = 1'b1;
          end
        end
      end
      S_DISPATCH: begin
        priority if (stat.func_free) begin
          if (stat.addr_out_of_range) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_INVALID;
          end else begin
            cmd.div_start    = 1'b1;
            cmd.div_sel_free = 1'b1;
          end
        end else if (stat.head_valid) begin
          cmd.link_rd = 1'b1;
        end else if (stat.have_untouched) begin
          cmd.take_new = 1'b1;
        end else begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_EMPTY;
        end
      end
      S_ALLOC_POP: cmd.pop    = 1'b1;
      S_MUL:       cmd.mul_en = 1'b1;
      S_ADD:       cmd.add_en = 1'b1;
      S_FREE_DIV: begin
        if (stat.div_done) begin
          if (stat.div_bad_free) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_INVALID;
          end else begin
            cmd.push = 1'b1;
          end
        end
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator
//
// Requests enter on start with in_func (0 allocate, 1 free) and
// in_block_address; one is taken at a clock edge where start is high and busy
// is low. Every request gives exactly one result: out_status and
// out_granted_address, shown for a single cycle while out_valid is high. The
// receiver cannot stall; out_valid is never held.
// The pool is set through cfg_we / cfg_index / cfg_wdata (0 base, 1 size, 2
// block size); a write to 0-2 empties the pool. Write only while busy is low.
// Sequence: each request first runs the configuration check, a 32-step
// shared divider (size / block size) that is skipped for an obviously bad
// configuration. An allocate then pops a block from the free list or takes an
// untouched one; a free runs the divider again on the address offset. A
// failed check, an empty pool or an out-of-range free ends the request early.
// busy falls the cycle after out_valid, so the next item can be taken in the
// cycle after the result.
// Synchronous reset (rst_n low) restores base 0, size 0, block size 8, an
// empty free list and no block handed out. Link memory is not cleared.
`default_nettype none

module fixed_block_pool_allocator import fbpa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_func,
  input  wire logic [ADDR_W-1:0] in_block_address,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [ADDR_W-1:0]      out_granted_address,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [ADDR_W-1:0] cfg_wdata
);

  fbpa_cmd_t  cmd;
  fbpa_stat_t stat;

  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  fbpa_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_func             (in_func),
    .in_block_address    (in_block_address),
    .cmd                 (cmd),
    .stat                (stat),
    .out_status          (out_status),
    .out_granted_address (out_granted_address)
  );

endmodule

`default_nettype wire

FILE: design/fbpa_checker.sv
// Port-level checker for the allocator, bound to the top level
`default_nettype none

`include "fixed_block_pool_allocator_assert.svh"

module fbpa_checker import fbpa_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire logic [1:0]        out_status,
  input wire logic [ADDR_W-1:0] out_granted_address
);

  `FBPA_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !busy && !out_valid)
  `FBPA_ASSERT(a_accept_busy, start && !busy |=> busy)
  `FBPA_ASSERT(a_result_single, out_valid |=> !out_valid && !busy)
  `FBPA_ASSERT(a_result_in_busy, out_valid |-> busy)
  `FBPA_ASSERT(a_fail_no_addr, out_valid && out_status != ST_OK |-> out_granted_address == '0)

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the fixed block pool allocator: table-driven and random requests
module tb;
  import fbpa_pkg::*;

  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int RANDOM_ITEMS = 1700;

  typedef struct packed {
    status_t           st;
    logic [ADDR_W-1:0] addr;
  } reply_t;

  typedef struct packed {
    logic              is_cfg;
    logic [1:0]        idx;
    logic [ADDR_W-1:0] val;
    logic              func;
    logic              typed;
    status_t           st;
    logic [ADDR_W-1:0] addr;
  } step_t;

  logic              clk, rst_n, start, busy, in_func, out_valid, cfg_we;
  logic [ADDR_W-1:0] in_block_address, out_granted_address, cfg_wdata;
  logic [1:0]        out_status, cfg_index;

  // mirror of the pool
  logic [ADDR_W-1:0]  pool_base;
  logic [SIZE_W-1:0]  pool_size;
  logic [BLOCK_W-1:0] blk_size;
  logic [HEAD_W-1:0]  list_top;
  logic [HEAD_W-1:0]  next_link [MAX_BLOCKS];
  logic [HEAD_W-1:0]  fresh_count;
  int                 pool_blocks;

  reply_t            replies_due [$];
  logic [ADDR_W-1:0] held [$];
  int                errors, idle_pct, sent;
  int                idle_plan [3] = '{0, 56, 32};

  step_t script [$] = '{
    '{1'b0, REG_BASE,  48'h0,              FUNC_ALLOC, 1'b1, ST_BAD_CFG, 48'h0},
    '{1'b0, REG_BASE,  48'hFFFF_FFFF_FFFF, FUNC_FREE,  1'b1, ST_BAD_CFG, 48'h0},
    '{1'b1, REG_BASE,  48'h1000,           FUNC_ALLOC, 1'b0, ST_OK,      48'h0},
    '{1'b1, REG_SIZE,  48'd32,             FUNC_ALLOC, 1'b0, ST_OK,      48'h0},
    '{1'b1, REG_BLOCK, 48'd16,             FUNC_ALLOC, 1'b0, ST_OK,      48'h0},
    '{1'b0, REG_BASE,  48'h0,              FUNC_ALLOC, 1'b1, ST_OK,      48'h1000},
    '{1'b0, REG_BASE,  48'h0,              FUNC_ALLOC, 1'b1, ST_OK,      48'h1010},
    '{1'b0, REG_BASE,  48'h0,              FUNC_ALLOC, 1'b1, ST_EMPTY,   48'h0},
    '{1'b0, REG_BASE,  48'h1010,           FUNC_FREE,  1'b1, ST_OK,      48'h0},
    '{1'b0, REG_BASE,  48'h1008,           FUNC_FREE,  1'b1, ST_INVALID, 48'h0},
    '{1'b0, REG_BASE,  48'h0FF0,           FUNC_FREE,  1'b1, ST_INVALID, 48'h0},
    '{1'b0, REG_BASE,  48'h1020,           FUNC_FREE,  1'b1, ST_INVALID, 48'h0},
    '{1'b0, REG_BASE,  48'h0,              FUNC_ALLOC, 1'b1, ST_OK,      48'h1010},
    '{1'b0, REG_BASE,  48'h1000,           FUNC_FREE,  1'b1, ST_OK,      48'h0},
    // double free: the block now links to itself
    '{1'b0, REG_BASE,  48'h1000,           FUNC_FREE,  1'b0, ST_OK,      48'h0},
    '{1'b0, REG_BASE,  48'h0,              FUNC_ALLOC, 1'b0, ST_OK,      48'h0},
    // unused index leaves the pool as it is
    '{1'b1, REG_NONE,  48'hFFFF_FFFF_FFFF, FUNC_ALLOC, 1'b0, ST_OK,      48'h0},
    '{1'b0, REG_BASE,  48'h0,              FUNC_ALLOC, 1'b0, ST_OK,      48'h0},
    '{1'b1, REG_BLOCK, 48'd7,              FUNC_ALLOC, 1'b0, ST_OK,      48'h0},
    '{1'b0, REG_BASE,  48'h0,              FUNC_ALLOC, 1'b1, ST_BAD_CFG, 48'h0},
    '{1'b1, REG_BLOCK, 48'd12,             FUNC_ALLOC, 1'b0, ST_OK,      48'h0},
    '{1'b0, REG_BASE,  48'h0,              FUNC_ALLOC, 1'b1, ST_BAD_CFG, 48'h0},
    '{1'b1, REG_BLOCK, 48'd8,              FUNC_ALLOC, 1'b0, ST_OK,      48'h0},
    '{1'b1, REG_SIZE,  48'd8200,           FUNC_ALLOC, 1'b0, ST_OK,      48'h0},
    '{1'b0, REG_BASE,  48'h0,              FUNC_ALLOC, 1'b1, ST_BAD_CFG, 48'h0},
    '{1'b1, REG_SIZE,  48'd0,              FUNC_ALLOC, 1'b0, ST_OK,      48'h0},
    '{1'b0, REG_BASE,  48'h1000,           FUNC_FREE,  1'b1, ST_BAD_CFG, 48'h0},
    // pool at the top of the address space, second block wraps to zero
    '{1'b1, REG_BASE,  48'hFFFF_FFFF_FFF0, FUNC_ALLOC, 1'b0, ST_OK,      48'h0},
    '{1'b1, REG_SIZE,  48'd64,             FUNC_ALLOC, 1'b0, ST_OK,      48'h0},
    '{1'b1, REG_BLOCK, 48'd16,             FUNC_ALLOC, 1'b0, ST_OK,      48'h0},
    '{1'b0, REG_BASE,  48'h0,              FUNC_ALLOC, 1'b1, ST_OK,      48'hFFFF_FFFF_FFF0},
    '{1'b0, REG_BASE,  48'h0,              FUNC_ALLOC, 1'b1, ST_OK,      48'h0},
    '{1'b0, REG_BASE,  48'hFFFF_FFFF_FFF0, FUNC_FREE,  1'b1, ST_OK,      48'h0},
    '{1'b0, REG_BASE,  48'h0,              FUNC_FREE,  1'b1, ST_INVALID, 48'h0},
    '{1'b1, REG_SIZE,  48'hFFFF_FFFF,      FUNC_ALLOC, 1'b0, ST_OK,      48'h0},
    '{1'b1, REG_BLOCK, 48'hFFFF,           FUNC_ALLOC, 1'b0, ST_OK,      48'h0},
    '{1'b0, REG_BASE,  48'h0,              FUNC_ALLOC, 1'b1, ST_BAD_CFG, 48'h0},
    // largest valid pool
    '{1'b1, REG_BASE,  48'h1,              FUNC_ALLOC, 1'b0, ST_OK,      48'h0},
    '{1'b1, REG_SIZE,  48'h3FF_FC00,       FUNC_ALLOC, 1'b0, ST_OK,      48'h0},
    '{1'b1, REG_BLOCK, 48'hFFFF,           FUNC_ALLOC, 1'b0, ST_OK,      48'h0},
    '{1'b0, REG_BASE,  48'h3FE_FC02,       FUNC_FREE,  1'b1, ST_OK,      48'h0},
    '{1'b0, REG_BASE,  48'h0,              FUNC_ALLOC, 1'b1, ST_OK,      48'h3FE_FC02},
    '{1'b0, REG_BASE,  48'h0,              FUNC_ALLOC, 1'b1, ST_OK,      48'h1}
  };

  fixed_block_pool_allocator dut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void flag(input string msg);
    if (errors < 10) $display("%s", msg);
    errors++;
  endfunction

  function automatic reply_t serve_request(input logic f, input logic [ADDR_W-1:0] a);
    reply_t          r;
    logic [HEAD_W-1:0] idx;
    logic [ADDR_W:0] pool_end;
    r.st = ST_OK;
    r.addr = '0;
    idx = '0;
    pool_end = pool_base + pool_size;
    if (pool_base == 0 || pool_size == 0 || blk_size < MIN_BLOCK
        || pool_size % blk_size != 0 || pool_size / blk_size > MAX_QUO) begin
      r.st = ST_BAD_CFG;
    end else if (f == FUNC_ALLOC) begin
      if (list_top < HEAD_MAX) begin
        idx = list_top;
        list_top = next_link[idx[IDX_W-1:0]];
      end else if (fresh_count < pool_size / blk_size) begin
        idx = fresh_count;
        fresh_count++;
      end else begin
        r.st = ST_EMPTY;
      end
      if (r.st == ST_OK) r.addr = pool_base + idx * blk_size;
    end else if (a < pool_base || a >= pool_end || (a - pool_base) % blk_size != 0) begin
      r.st = ST_INVALID;
    end else begin
      idx = HEAD_W'((a - pool_base) / blk_size);
      next_link[idx[IDX_W-1:0]] = list_top;
      list_top = idx;
    end
    return r;
  endfunction

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (rst_n && out_valid) begin
      if (replies_due.size() == 0) begin
        flag($sformatf("unexpected reply: status %0d addr %h", out_status,
                       out_granted_address));
      end else begin
        want = replies_due.pop_front();
        if (out_status !== want.st)
          flag($sformatf("status: expected %0d, got %0d", want.st, out_status));
        if (out_granted_address !== want.addr)
          flag($sformatf("granted address: expected %h, got %h", want.addr,
                         out_granted_address));
      end
    end
  end

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0 || busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [ADDR_W-1:0] d);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BASE:  pool_base = d;
      REG_SIZE:  pool_size = d[SIZE_W-1:0];
      REG_BLOCK: blk_size = d[BLOCK_W-1:0];
      default: ;
    endcase
    if (idx != REG_NONE) begin
      list_top = HEAD_MAX;
      fresh_count = '0;
    end
    @(posedge clk);
  endtask

  task automatic send(input logic f, input logic [ADDR_W-1:0] a, input logic use_fixed,
                      input reply_t fixed, output reply_t got);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 100)) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= f;
    in_block_address <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    got = serve_request(f, a);
    replies_due.push_back(use_fixed ? fixed : got);
    sent++;
  endtask

  task automatic pick_pool(input logic biggest, output logic bad);
    logic [ADDR_W-1:0]  b, hi;
    logic [SIZE_W-1:0]  sz;
    logic [BLOCK_W-1:0] bs;
    int                 n;
    case ($urandom_range(9))
      0: bs = 16'hFFFF;
      1: bs = BLOCK_W'($urandom_range(8, 65535));
      2: bs = BLOCK_W'($urandom_range(9, 40));
      default: bs = BLOCK_W'(8 * $urandom_range(1, 8));
    endcase
    case ($urandom_range(9))
      0: n = MAX_BLOCKS;
      1: n = $urandom_range(1, MAX_BLOCKS);
      default: n = $urandom_range(1, 12);
    endcase
    case ($urandom_range(9))
      0: b = ADDR_W'({$urandom(), $urandom()}) | 48'hFFFF_FFFF_F000;
      1: b = 48'd1;
      default: b = ADDR_W'({$urandom(), $urandom()});
    endcase
    if (biggest) begin
      bs = 16'hFFFF;
      n = MAX_BLOCKS;
    end
    sz = SIZE_W'(n) * bs;
    bad = !biggest && $urandom_range(99) < 15;
    if (bad) begin
      case ($urandom_range(4))
        0: b = '0;
        1: sz = '0;
        2: bs = BLOCK_W'($urandom_range(0, 7));
        3: sz = sz + 1;
        default: begin
          n = $urandom_range(MAX_BLOCKS + 1, 4096);
          sz = SIZE_W'(n) * bs;
        end
      endcase
    end
    pool_blocks = n;
    // upper bits beyond the register width must be dropped
    hi = ($urandom_range(3) == 0) ? ADDR_W'({$urandom(), $urandom()}) : '0;
    write_reg(REG_BASE, b);
    write_reg(REG_SIZE, {hi[ADDR_W-1:SIZE_W], sz});
    write_reg(REG_BLOCK, {hi[ADDR_W-1:BLOCK_W], bs});
    if ($urandom_range(3) == 0) write_reg(REG_NONE, ADDR_W'({$urandom(), $urandom()}));
  endtask

  initial begin : run
    reply_t            got;
    step_t             row;
    logic [ADDR_W-1:0] a;
    logic              bad;
    int                p, k, phase;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_func <= FUNC_ALLOC;
    in_block_address <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_BASE;
    cfg_wdata <= '0;
    pool_base = '0;
    pool_size = '0;
    blk_size = BLOCK_W'(8);
    list_top = HEAD_MAX;
    fresh_count = '0;
    errors = 0;
    sent = 0;
    idle_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      row = script[i];
      if (row.is_cfg) write_reg(row.idx, row.val);
      else send(row.func, row.val, row.typed, reply_t'{row.st, row.addr}, got);
    end

    // receiver cannot stall, so only the sender idles
    phase = 0;
    while (sent < RANDOM_ITEMS + script.size()) begin
      pick_pool(phase == 0, bad);
      idle_pct = idle_plan[phase % 3];
      held.delete();
      repeat (bad ? 12 : $urandom_range(80, 260)) begin
        p = $urandom_range(99);
        if (p < 45 || (p < 80 && held.size() == 0)) begin
          send(FUNC_ALLOC, ADDR_W'({$urandom(), $urandom()}), 1'b0, '0, got);
          if (got.st == ST_OK) held.push_back(got.addr);
        end else if (p < 80) begin
          k = $urandom_range(held.size() - 1);
          a = held[k];
          held.delete(k);
          send(FUNC_FREE, a, 1'b0, '0, got);
        end else if (p < 83) begin
          a = pool_base + ADDR_W'($urandom_range(pool_blocks - 1)) * blk_size;
          send(FUNC_FREE, a, 1'b0, '0, got);
        end else begin
          case ($urandom_range(3))
            0: a = ADDR_W'({$urandom(), $urandom()});
            1: a = pool_base + ADDR_W'($urandom_range(1, 7));
            2: a = pool_base - ADDR_W'($urandom_range(1, 64));
            default: a = pool_base + pool_size + ADDR_W'($urandom_range(0, 3)) * blk_size;
          endcase
          send(FUNC_FREE, a, 1'b0, '0, got);
        end
        if ($urandom_range(99) < 2) settle();
      end
      phase++;
    end

    settle();
    repeat (100) @(posedge clk);
    if (errors == 0 && replies_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: fixed_block_pool_allocator.f
+incdir+design
design/fbpa_pkg.sv
design/fbpa_div.sv
design/fbpa_datapath.sv
design/fbpa_ctrl.sv
design/fixed_block_pool_allocator.sv
design/fbpa_checker.sv
verif/tb.sv
